### hdl/ipv4fhc_pkg.sv
// types, constants and the checksum fold for the ipv4 forward header check
// shared by the front, queue and back modules; depends on nothing
package ipv4fhc_pkg;

	localparam int CNT_W       = 5;
	localparam int WORD_W      = 16;
	localparam int MIN_IHL     = 5;
	localparam int TTL_WORD    = 4;
	localparam int SUM_WORD    = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [WORD_W-1:0] TTL_ONE = 16'h0100;
	localparam logic [1:0]        FB_FULL = 2'd2;

	typedef enum logic [1:0] {
		PH_START,
		PH_HEADER,
		PH_PAYLOAD,
		PH_DISCARD
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_CSUM  = 3'd1,
		ST_TTL   = 3'd2,
		ST_IHL   = 3'd3,
		ST_TRUNC = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CMD_DROP,
		CMD_PASS,
		CMD_HEADER
	} cmd_t;

	typedef enum logic {
		B_IDLE,
		B_HDR
	} bstate_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [WORD_W-1:0] word;
		logic              last;
		logic [1:0]        fb;
		status_t           status;
		logic [CNT_W-1:0]  count;
	} qent_t;

	typedef struct packed {
		logic              en;
		logic [CNT_W-1:0]  addr;
		logic [WORD_W-1:0] data;
	} stw_t;

	function automatic logic [WORD_W-1:0] add_fold(input logic [WORD_W-1:0] s,
		input logic [WORD_W-1:0] w);
		logic [WORD_W:0] t;
		t = {1'b0, s} + {1'b0, w};
		return t[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, t[WORD_W]};
	endfunction

endpackage

### hdl/ipv4_forward_header_check_core.sv
// ipv4 forward header check: the last header word pushes a header command into the
// queue; the back pops it and sends the stored header from its header state, one
// word per cycle while out_stall is low; payload words and drop results are popped
// from the queue into the output register; the front takes one word per cycle while
// the queue is not full; the start of the next packet waits while the back is still
// sending the previous header from the store; arst_n clears phase, counters, queue
// pointers and the output valid; the header store and data registers are not reset
module ipv4_forward_header_check_core #(
	parameter int MAX_HEADER_WORDS = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] word,
	input  logic        last,
	input  logic [1:0]  final_bytes,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] word_res,
	output logic        last_res,
	output logic [1:0]  final_bytes_res,
	output logic [2:0]  status
);
	import ipv4fhc_pkg::*;

	logic  push, q_full, pop, q_empty, hdr_done;
	qent_t push_ent, pop_ent;
	stw_t  st_wr;

	ipv4fhc_front #(
		.MaxHeaderWords(MAX_HEADER_WORDS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.word        (word),
		.last        (last),
		.final_bytes (final_bytes),
		.push        (push),
		.push_ent    (push_ent),
		.q_full      (q_full),
		.st_wr       (st_wr),
		.hdr_done    (hdr_done)
	);

	ipv4fhc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.full     (q_full),
		.pop      (pop),
		.pop_ent  (pop_ent),
		.empty    (q_empty)
	);

	ipv4fhc_back #(
		.MaxHeaderWords(MAX_HEADER_WORDS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_ent           (pop_ent),
		.pop             (pop),
		.st_wr           (st_wr),
		.hdr_done        (hdr_done),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.word_res        (word_res),
		.last_res        (last_res),
		.final_bytes_res (final_bytes_res),
		.status          (status)
	);

endmodule

### hdl/ipv4fhc_queue.sv
// short command queue between the front and the back
// depends on ipv4fhc_pkg
module ipv4fhc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ipv4fhc_pkg::qent_t  push_ent,
	output logic                full,
	input  logic                pop,
	output ipv4fhc_pkg::qent_t  pop_ent,
	output logic                empty
);
	import ipv4fhc_pkg::*;

	qent_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_ent = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

### hdl/ipv4fhc_front.sv
// front: takes packet words, stores the header, checks ihl, length, checksum and ttl
// depends on ipv4fhc_pkg; feeds ipv4fhc_queue and the header store in ipv4fhc_back
module ipv4fhc_front #(
	parameter int MaxHeaderWords = 30
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        word,
	input  logic               last,
	input  logic [1:0]         final_bytes,
	output logic               push,
	output ipv4fhc_pkg::qent_t push_ent,
	input  logic               q_full,
	output ipv4fhc_pkg::stw_t  st_wr,
	input  logic               hdr_done
);
	import ipv4fhc_pkg::*;

	phase_t            phase_q, phase_n;
	logic [CNT_W-1:0]  wc_q, wc_n;
	logic [CNT_W-1:0]  hw_q, hw_n;
	logic [WORD_W-1:0] sum_q, sum_n;
	logic [WORD_W-1:0] sum2_q, sum2_n;
	logic [WORD_W-1:0] csum_q, csum_n;
	logic [7:0]        ttl_q, ttl_n;
	logic              busy_q, busy_n;

	logic              accept;
	logic [3:0]        ihl;
	logic [CNT_W-1:0]  hw_calc;
	logic              ihl_bad;
	logic [CNT_W-1:0]  eff_wc, eff_hw, wc_inc;
	logic [WORD_W-1:0] eff_sum, eff_sum2, fold_sum, fold_sum2;
	logic              trunc;
	logic              drop;
	status_t           drop_code;

	assign in_stall = q_full || (phase_q == PH_START && busy_q);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		ihl     = word[11:8];
		hw_calc = {ihl, 1'b0};
		ihl_bad = (ihl < 4'(MIN_IHL)) || (hw_calc > CNT_W'(MaxHeaderWords));

		if (phase_q == PH_START) begin
			eff_wc   = '0;
			eff_hw   = hw_calc;
			eff_sum  = '0;
			eff_sum2 = '0;
		end else begin
			eff_wc   = wc_q;
			eff_hw   = hw_q;
			eff_sum  = sum_q;
			eff_sum2 = sum2_q;
		end
		wc_inc    = eff_wc + 1'b1;
		fold_sum  = add_fold(eff_sum, word);
		fold_sum2 = add_fold(eff_sum2,
			(eff_wc == CNT_W'(TTL_WORD)) ? (word - TTL_ONE) : word);
		trunc = (eff_wc >= eff_hw) || (eff_wc >= CNT_W'(MaxHeaderWords))
			|| (last && ((wc_inc < eff_hw) || (final_bytes != FB_FULL)));

		phase_n   = phase_q;
		wc_n      = wc_q;
		hw_n      = hw_q;
		sum_n     = sum_q;
		sum2_n    = sum2_q;
		csum_n    = csum_q;
		ttl_n     = ttl_q;
		busy_n    = busy_q;
		push      = 1'b0;
		push_ent  = '0;
		st_wr     = '0;
		drop      = 1'b0;
		drop_code = ST_OK;

		if (hdr_done) begin
			busy_n = 1'b0;
		end

		if (accept) begin
			unique case (phase_q) inside
				PH_PAYLOAD: begin
					push            = 1'b1;
					push_ent.cmd    = CMD_PASS;
					push_ent.word   = word;
					push_ent.last   = last;
					push_ent.fb     = final_bytes;
					push_ent.status = ST_OK;
					if (last) begin
						phase_n = PH_START;
					end
				end
				PH_DISCARD: begin
					if (last) begin
						phase_n = PH_START;
					end
				end
				PH_START, PH_HEADER: begin
					if (phase_q == PH_START && ihl_bad) begin
						drop      = 1'b1;
						drop_code = ST_IHL;
					end else if (trunc) begin
						drop      = 1'b1;
						drop_code = ST_TRUNC;
					end else begin
						st_wr.en   = 1'b1;
						st_wr.addr = eff_wc;
						st_wr.data = word;
						hw_n       = eff_hw;
						wc_n       = wc_inc;
						sum_n      = eff_sum;
						sum2_n     = eff_sum2;
						if (eff_wc != CNT_W'(SUM_WORD)) begin
							sum_n  = fold_sum;
							sum2_n = fold_sum2;
						end else begin
							csum_n = word;
						end
						if (eff_wc == CNT_W'(TTL_WORD)) begin
							ttl_n = word[15:8];
						end
						if (wc_inc < eff_hw) begin
							phase_n = PH_HEADER;
						end else if (~fold_sum != csum_q) begin
							drop      = 1'b1;
							drop_code = ST_CSUM;
						end else if (ttl_q <= 8'd1) begin
							drop      = 1'b1;
							drop_code = ST_TTL;
						end else begin
							push           = 1'b1;
							push_ent.cmd   = CMD_HEADER;
							push_ent.word  = ~fold_sum2;
							push_ent.last  = last;
							push_ent.fb    = FB_FULL;
							push_ent.count = eff_hw;
							busy_n         = 1'b1;
							phase_n        = last ? PH_START : PH_PAYLOAD;
						end
					end
				end
				default: begin
					phase_n = PH_START;
				end
			endcase
		end

		if (drop) begin
			push            = 1'b1;
			push_ent.cmd    = CMD_DROP;
			push_ent.word   = '0;
			push_ent.last   = 1'b1;
			push_ent.fb     = FB_FULL;
			push_ent.status = drop_code;
			phase_n         = last ? PH_START : PH_DISCARD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			wc_q    <= '0;
			hw_q    <= '0;
			sum_q   <= '0;
			sum2_q  <= '0;
			csum_q  <= '0;
			ttl_q   <= '0;
			busy_q  <= 1'b0;
		end else begin
			phase_q <= phase_n;
			wc_q    <= wc_n;
			hw_q    <= hw_n;
			sum_q   <= sum_n;
			sum2_q  <= sum2_n;
			csum_q  <= csum_n;
			ttl_q   <= ttl_n;
			busy_q  <= busy_n;
		end
	end

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && st_wr.en))
		else $error("header store written while header is being sent");

endmodule

### hdl/ipv4fhc_back.sv
// back: holds the header store, sends rewritten headers, drop results and payload
// depends on ipv4fhc_pkg; pops entries from ipv4fhc_queue
module ipv4fhc_back #(
	parameter int MaxHeaderWords = 30
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  ipv4fhc_pkg::qent_t q_ent,
	output logic               pop,
	input  ipv4fhc_pkg::stw_t  st_wr,
	output logic               hdr_done,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        word_res,
	output logic               last_res,
	output logic [1:0]         final_bytes_res,
	output logic [2:0]         status
);
	import ipv4fhc_pkg::*;

	localparam int AW = $clog2(MaxHeaderWords);

	logic [WORD_W-1:0] store_q [MaxHeaderWords];

	bstate_t           state_q, state_n;
	logic [AW-1:0]     idx_q, idx_n;
	logic [CNT_W-1:0]  cnt_q, cnt_n;
	logic              hlast_q, hlast_n;
	logic [WORD_W-1:0] hsum_q, hsum_n;

	logic              out_valid_q, out_valid_n;
	logic [WORD_W-1:0] word_q, word_n;
	logic              last_q, last_n;
	logic [1:0]        fb_q, fb_n;
	status_t           status_q, status_n;

	logic              can_load;
	logic              is_last_idx;
	logic [WORD_W-1:0] rd_word;

	assign out_valid       = out_valid_q;
	assign word_res        = word_q;
	assign last_res        = last_q;
	assign final_bytes_res = fb_q;
	assign status          = status_q;

	always_ff @(posedge clk) begin
		if (st_wr.en) begin
			store_q[st_wr.addr[AW-1:0]] <= st_wr.data;
		end
	end

	always_comb begin
		can_load    = !out_valid_q || !out_stall;
		rd_word     = store_q[idx_q];
		is_last_idx = (CNT_W'(idx_q) == (cnt_q - 1'b1));

		state_n     = state_q;
		idx_n       = idx_q;
		cnt_n       = cnt_q;
		hlast_n     = hlast_q;
		hsum_n      = hsum_q;
		pop         = 1'b0;
		hdr_done    = 1'b0;
		out_valid_n = out_valid_q;
		word_n      = word_q;
		last_n      = last_q;
		fb_n        = fb_q;
		status_n    = status_q;

		if (can_load) begin
			out_valid_n = 1'b0;
		end

		unique case (state_q)
			B_IDLE: begin
				if (can_load && !q_empty) begin
					pop = 1'b1;
					if (q_ent.cmd == CMD_HEADER) begin
						state_n = B_HDR;
						idx_n   = '0;
						cnt_n   = q_ent.count;
						hlast_n = q_ent.last;
						hsum_n  = q_ent.word;
					end else begin
						out_valid_n = 1'b1;
						word_n      = q_ent.word;
						last_n      = q_ent.last;
						fb_n        = q_ent.fb;
						status_n    = q_ent.status;
					end
				end
			end
			B_HDR: begin
				if (can_load) begin
					out_valid_n = 1'b1;
					if (idx_q == AW'(TTL_WORD)) begin
						word_n = rd_word - TTL_ONE;
					end else if (idx_q == AW'(SUM_WORD)) begin
						word_n = hsum_q;
					end else begin
						word_n = rd_word;
					end
					last_n   = hlast_q && is_last_idx;
					fb_n     = FB_FULL;
					status_n = ST_OK;
					if (is_last_idx) begin
						state_n  = B_IDLE;
						hdr_done = 1'b1;
					end else begin
						idx_n = idx_q + 1'b1;
					end
				end
			end
			default: begin
				state_n = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			idx_q       <= '0;
			cnt_q       <= '0;
			hlast_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			idx_q       <= idx_n;
			cnt_q       <= cnt_n;
			hlast_q     <= hlast_n;
			out_valid_q <= out_valid_n;
		end
	end

	always_ff @(posedge clk) begin
		hsum_q   <= hsum_n;
		word_q   <= word_n;
		last_q   <= last_n;
		fb_q     <= fb_n;
		status_q <= status_n;
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_HDR) |-> (CNT_W'(idx_q) < cnt_q))
		else $error("header index past header length");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_done |=> (state_q == B_IDLE))
		else $error("header sending did not finish");

endmodule
